// ===== hdl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared constants and types for the bounding sphere merge core
// Defines the default coordinate width, the threshold register and the codes
// that report which way the enclosing sphere was formed.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // default coordinate width (signed fixed point)
  localparam int COORD_BITS_DEF = 32;

  // coincidence threshold register
  localparam int          THRESH_W     = 16;
  localparam logic [15:0] THRESH_RESET = 16'd66;

  // how the result sphere was formed
  typedef enum logic [1:0] {
    MC_MERGE    = 2'd0,
    MC_FIRST    = 2'd1,
    MC_SECOND   = 2'd2,
    MC_COINCIDE = 2'd3
  } merge_case_t;

endpackage

// ===== hdl/bounding_sphere_merge_core.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_merge_core: smallest sphere enclosing two spheres
// Pipelined core: differences, squares, a bit-per-cell square root chain,
// case selection, the offset product and a bit-per-cell divider chain.
// ----------------------------------------------------------------------------
// A new sphere pair is taken every clock (busy is always low) and its result
// appears on the out_ ports, marked by out_valid, after the difference, square
// and sum stages, the square root chain, the radius, product and numerator
// stages, the divider chain and the output register; the square root chain
// gives one root bit per cell, the divider chain one quotient bit per cell.
// The receiver cannot stall, so each result is valid for one cycle only.
// cfg_wr_data sets the coincidence threshold in raw fixed-point units and may
// only change while no item is in flight.
module bounding_sphere_merge_core #(
  parameter int COORD_BITS = bsm_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bsm_pkg::THRESH_W-1:0]  cfg_wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_first_center_x,
  input  logic signed [COORD_BITS-1:0]  in_first_center_y,
  input  logic signed [COORD_BITS-1:0]  in_first_center_z,
  input  logic [COORD_BITS-2:0]         in_first_radius,
  input  logic signed [COORD_BITS-1:0]  in_second_center_x,
  input  logic signed [COORD_BITS-1:0]  in_second_center_y,
  input  logic signed [COORD_BITS-1:0]  in_second_center_z,
  input  logic [COORD_BITS-2:0]         in_second_radius,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_merged_center_x,
  output logic signed [COORD_BITS-1:0]  out_merged_center_y,
  output logic signed [COORD_BITS-1:0]  out_merged_center_z,
  output logic [COORD_BITS-2:0]         out_merged_radius,
  output logic [1:0]                    out_merge_case
);

  localparam int C      = COORD_BITS;
  localparam int DW     = C + 1;            // magnitude of a coordinate difference
  localparam int SQW    = 2 * DW + 2;       // radicand width
  localparam int ROOT_W = SQW / 2;          // distance width
  localparam int RW     = C - 1;            // radius width
  localparam int NW     = DW + ROOT_W;      // offset numerator width
  localparam int QW     = DW;               // offset quotient width
  localparam int H      = ROOT_W / 2;       // low half of the step factor
  localparam int HH     = ROOT_W - H;
  localparam int LAT    = 7 + ROOT_W + QW;

  // side data carried through the square root chain
  localparam int SS_W = 6 * C + 3 + 3 * DW + 2 * RW;
  // side data carried through the divider chain
  localparam int DS_W = 6 * C + 3 + 2 + RW + 1;

  logic [bsm_pkg::THRESH_W-1:0] thresh_r;
  logic                         accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= bsm_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // stage 1: coordinate differences
  logic                        s1_vld_r;
  logic [2:0][C-1:0]           s1_c1_r, s1_c2_r;
  logic [2:0]                  s1_neg_r;
  logic [2:0][DW-1:0]          s1_ad_r;
  logic [RW-1:0]               s1_r1_r, s1_r2_r;
  logic [2:0][C-1:0]           in_c1, in_c2;
  logic [2:0][DW-1:0]          diff;
  logic [2:0][DW-1:0]          ad_nxt;

  assign in_c1 = {in_first_center_z, in_first_center_y, in_first_center_x};
  assign in_c2 = {in_second_center_z, in_second_center_y, in_second_center_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]   = {in_c2[k][C-1], in_c2[k]} - {in_c1[k][C-1], in_c1[k]};
      ad_nxt[k] = diff[k][DW-1] ? (~diff[k] + 1'b1) : diff[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_c1_r <= in_c1;
    s1_c2_r <= in_c2;
    for (int k = 0; k < 3; k++) begin
      s1_neg_r[k] <= diff[k][DW-1];
    end
    s1_ad_r <= ad_nxt;
    s1_r1_r <= in_first_radius;
    s1_r2_r <= in_second_radius;
  end

  // stage 2: squares
  logic                        s2_vld_r;
  logic [2:0][2*DW-1:0]        s2_sq_r;
  logic [SS_W-1:0]             s1_side, s2_side_r, s3_side_r;

  assign s1_side = {s1_c1_r, s1_c2_r, s1_neg_r, s1_ad_r, s1_r1_r, s1_r2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s2_sq_r[k] <= s1_ad_r[k] * s1_ad_r[k];
    end
    s2_side_r <= s1_side;
  end

  // stage 3: sum of squares
  logic           s3_vld_r;
  logic [SQW-1:0] s3_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_rad_r  <= {2'b00, s2_sq_r[0]} + {2'b00, s2_sq_r[1]} + {2'b00, s2_sq_r[2]};
    s3_side_r <= s2_side_r;
  end

  // square root chain, one root bit per cell
  logic                sq_vld  [ROOT_W+1];
  logic [SQW-1:0]      sq_rad  [ROOT_W+1];
  logic [ROOT_W+2:0]   sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   sq_root [ROOT_W+1];
  logic [SS_W-1:0]     sq_side [ROOT_W+1];

  assign sq_vld[0]  = s3_vld_r;
  assign sq_rad[0]  = s3_rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    bsm_sqrt_cell #(
      .RAD_W  (SQW),
      .ROOT_W (ROOT_W),
      .IDX    (i),
      .SIDE_W (SS_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // stage r: radius, case and step factor
  logic [2:0][C-1:0]    q_c1, q_c2;
  logic [2:0]           q_neg;
  logic [2:0][DW-1:0]   q_ad;
  logic [RW-1:0]        q_r1, q_r2;
  logic [ROOT_W-1:0]    cdist;
  logic [ROOT_W:0]      rsum;
  logic [ROOT_W-1:0]    rad_full;
  bsm_pkg::merge_case_t mcase_nxt;
  logic [RW-1:0]        rad_out_nxt;

  assign {q_c1, q_c2, q_neg, q_ad, q_r1, q_r2} = sq_side[ROOT_W];
  assign cdist    = sq_root[ROOT_W];
  assign rsum     = {2'b00, q_r1} + {2'b00, q_r2} + {1'b0, cdist};
  assign rad_full = rsum[ROOT_W:1];

  always_comb begin
    if (cdist < {{(ROOT_W-bsm_pkg::THRESH_W){1'b0}}, thresh_r}) begin
      mcase_nxt   = bsm_pkg::MC_COINCIDE;
      rad_out_nxt = (q_r1 > q_r2) ? q_r1 : q_r2;
    end else if (rad_full < {3'b000, q_r1}) begin
      mcase_nxt   = bsm_pkg::MC_FIRST;
      rad_out_nxt = q_r1;
    end else if (rad_full < {3'b000, q_r2}) begin
      mcase_nxt   = bsm_pkg::MC_SECOND;
      rad_out_nxt = q_r2;
    end else begin
      mcase_nxt   = bsm_pkg::MC_MERGE;
      rad_out_nxt = (rad_full[ROOT_W-1:RW] != '0) ? {RW{1'b1}} : rad_full[RW-1:0];
    end
  end

  logic                 sr_vld_r;
  logic [ROOT_W-1:0]    sr_dist_r;
  logic [ROOT_W-1:0]    sr_step_r;
  logic [2:0][DW-1:0]   sr_ad_r;
  logic [DS_W-1:0]      sr_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_vld_r <= 1'b0;
    end else begin
      sr_vld_r <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    sr_dist_r <= cdist;
    sr_step_r <= rad_full - {3'b000, q_r1};
    sr_ad_r   <= q_ad;
    sr_side_r <= {q_c1, q_c2, q_neg, mcase_nxt, rad_out_nxt, (cdist == '0)};
  end

  // stage m: partial products of the offset numerator
  logic                  sm_vld_r;
  logic [ROOT_W-1:0]     sm_dist_r;
  logic [2:0][DW+H-1:0]  sm_pl_r;
  logic [2:0][DW+HH-1:0] sm_ph_r;
  logic [DS_W-1:0]       sm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_vld_r <= 1'b0;
    end else begin
      sm_vld_r <= sr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sm_pl_r[k] <= sr_ad_r[k] * sr_step_r[H-1:0];
      sm_ph_r[k] <= sr_ad_r[k] * sr_step_r[ROOT_W-1:H];
    end
    sm_dist_r <= sr_dist_r;
    sm_side_r <= sr_side_r;
  end

  // stage n: numerator sum
  logic                  sn_vld_r;
  logic [ROOT_W-1:0]     sn_dist_r;
  logic [2:0][NW-1:0]    sn_num_r;
  logic [DS_W-1:0]       sn_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_vld_r <= 1'b0;
    end else begin
      sn_vld_r <= sm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sn_num_r[k] <= {{(NW-DW-H){1'b0}}, sm_pl_r[k]} + {sm_ph_r[k], {H{1'b0}}};
    end
    sn_dist_r <= sm_dist_r;
    sn_side_r <= sm_side_r;
  end

  // divider chain, one quotient bit per cell
  logic                     dv_vld  [QW+1];
  logic [ROOT_W-1:0]        dv_div  [QW+1];
  logic [2:0][NW-1:0]       dv_num  [QW+1];
  logic [2:0][ROOT_W:0]     dv_rem  [QW+1];
  logic [2:0][QW-1:0]       dv_quo  [QW+1];
  logic [DS_W-1:0]          dv_side [QW+1];

  assign dv_vld[0]  = sn_vld_r;
  assign dv_div[0]  = sn_dist_r;
  assign dv_num[0]  = sn_num_r;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = sn_side_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] = {1'b0, sn_num_r[k][NW-1:QW]};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    bsm_div_cell #(
      .NUM_W  (NW),
      .DIV_W  (ROOT_W),
      .QUO_W  (QW),
      .IDX    (i),
      .SIDE_W (DS_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[i]),
      .in_div   (dv_div[i]),
      .in_num   (dv_num[i]),
      .in_rem   (dv_rem[i]),
      .in_quo   (dv_quo[i]),
      .in_side  (dv_side[i]),
      .out_vld  (dv_vld[i+1]),
      .out_div  (dv_div[i+1]),
      .out_num  (dv_num[i+1]),
      .out_rem  (dv_rem[i+1]),
      .out_quo  (dv_quo[i+1]),
      .out_side (dv_side[i+1])
    );
  end

  // output stage: apply offset and select the result sphere
  logic [2:0][C-1:0]    o_c1, o_c2;
  logic [2:0]           o_neg;
  logic [1:0]           o_case;
  logic [RW-1:0]        o_rad;
  logic                 o_dzero;
  logic [2:0][DW-1:0]   off;
  logic [2:0][C-1:0]    ctr_nxt;

  assign {o_c1, o_c2, o_neg, o_case, o_rad, o_dzero} = dv_side[QW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k] = o_dzero ? '0 : dv_quo[QW][k];
      case (o_case)
        bsm_pkg::MC_MERGE:  ctr_nxt[k] = o_neg[k] ? (o_c1[k] - off[k][C-1:0])
                                                  : (o_c1[k] + off[k][C-1:0]);
        bsm_pkg::MC_SECOND: ctr_nxt[k] = o_c2[k];
        default:            ctr_nxt[k] = o_c1[k];
      endcase
    end
  end

  logic                 out_vld_r;
  logic [2:0][C-1:0]    out_ctr_r;
  logic [RW-1:0]        out_rad_r;
  logic [1:0]           out_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_ctr_r  <= ctr_nxt;
    out_rad_r  <= o_rad;
    out_case_r <= o_case;
  end

  assign out_valid           = out_vld_r;
  assign out_merged_center_x = out_ctr_r[0];
  assign out_merged_center_y = out_ctr_r[1];
  assign out_merged_center_z = out_ctr_r[2];
  assign out_merged_radius   = out_rad_r;
  assign out_merge_case      = out_case_r;

`ifndef SYNTHESIS
  // every accepted item comes out after the fixed pipeline latency
  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("item lost in pipeline");

  // no result appears without an accepted item
  a_latency_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LAT !out_valid)
    else $error("result without item");

  // in a true merge the center step never exceeds the distance
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sr_vld_r && sr_side_r[RW+2:RW+1] == bsm_pkg::MC_MERGE) |-> (sr_step_r <= sr_dist_r))
    else $error("merge step exceeds distance");
`endif

endmodule

// ===== hdl/bsm_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// bsm_sqrt_cell: one digit of a pipelined integer square root
// Takes two radicand bits, decides one root bit and registers the partial
// remainder, the partial root and the side data for the next cell.
// ----------------------------------------------------------------------------
module bsm_sqrt_cell #(
  parameter int RAD_W  = 68,
  parameter int ROOT_W = 34,
  parameter int IDX    = 0,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [RAD_W-1:0]    in_rad,
  input  logic [ROOT_W+2:0]   in_rem,
  input  logic [ROOT_W-1:0]   in_root,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [RAD_W-1:0]    out_rad,
  output logic [ROOT_W+2:0]   out_rem,
  output logic [ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RMW = ROOT_W + 3;

  logic [RMW-1:0]    tmp;
  logic [RMW-1:0]    trial;
  logic              ge;
  logic              vld_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RMW-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;

  // bring down the next radicand pair and try a one in this root bit
  always_comb begin
    tmp      = {in_rem[RMW-3:0], in_rad[RAD_W-1-2*IDX -: 2]};
    trial    = {1'b0, in_root, 2'b01};
    ge       = (tmp >= trial);
    rem_nxt  = ge ? (tmp - trial) : tmp;
    root_nxt = {in_root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= in_rad;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

// ===== hdl/bsm_div_cell.sv =====
// ----------------------------------------------------------------------------
// bsm_div_cell: one quotient bit of a pipelined divider, three lanes
// Each lane shifts in one numerator bit, subtracts the shared divisor when it
// fits and registers remainder, quotient and side data for the next cell.
// ----------------------------------------------------------------------------
module bsm_div_cell #(
  parameter int NUM_W  = 67,
  parameter int DIV_W  = 34,
  parameter int QUO_W  = 33,
  parameter int IDX    = 0,
  parameter int SIDE_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [DIV_W-1:0]           in_div,
  input  logic [2:0][NUM_W-1:0]      in_num,
  input  logic [2:0][DIV_W:0]        in_rem,
  input  logic [2:0][QUO_W-1:0]      in_quo,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_vld,
  output logic [DIV_W-1:0]           out_div,
  output logic [2:0][NUM_W-1:0]      out_num,
  output logic [2:0][DIV_W:0]        out_rem,
  output logic [2:0][QUO_W-1:0]      out_quo,
  output logic [SIDE_W-1:0]          out_side
);

  logic [2:0][DIV_W:0]       tmp;
  logic [2:0]                ge;
  logic [2:0][DIV_W:0]       rem_nxt;
  logic [2:0][QUO_W-1:0]     quo_nxt;
  logic                      vld_r;
  logic [DIV_W-1:0]          div_r;
  logic [2:0][NUM_W-1:0]     num_r;
  logic [2:0][DIV_W:0]       rem_r;
  logic [2:0][QUO_W-1:0]     quo_r;
  logic [SIDE_W-1:0]         side_r;

  // restoring step per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tmp[k]     = {in_rem[k][DIV_W-1:0], in_num[k][QUO_W-1-IDX]};
      ge[k]      = (tmp[k] >= {1'b0, in_div});
      rem_nxt[k] = ge[k] ? (tmp[k] - {1'b0, in_div}) : tmp[k];
      quo_nxt[k] = {in_quo[k][QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    div_r  <= in_div;
    num_r  <= in_num;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_div  = div_r;
  assign out_num  = num_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;
  assign out_side = side_r;

endmodule
